// ===== rtl/two_stack_queue_defines.svh =====
// Assertion macros shared by the queue RTL.
`ifndef TWO_STACK_QUEUE_DEFINES_SVH
`define TWO_STACK_QUEUE_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define TSQ_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define TSQ_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/tsq_pkg.sv =====
// Types and constants of the two-stack queue.
package tsq_pkg;

    localparam int DATA_W = 32;
    localparam int LIMIT_W = 5;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 5'd16;

    localparam logic KIND_ENQ = 1'b0;
    localparam logic KIND_DEQ = 1'b1;

    localparam logic [1:0] ST_OK = 2'd0;
    localparam logic [1:0] ST_OVERFLOW = 2'd1;
    localparam logic [1:0] ST_UNDERFLOW = 2'd2;

    localparam logic signed [DATA_W-1:0] UNDERFLOW_DATA = 32'shFFFF_FFFF;

    typedef struct packed {
        logic                     kind;
        logic signed [DATA_W-1:0] data_in;
    } item_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] data_out;
        logic [1:0]               status;
    } result_t;

endpackage

// ===== rtl/two_stack_queue.sv =====
// Two-stack FIFO queue: top level with sequencer, counters and both stack RAMs.
// Enqueue and underflow: the done strobe follows start in the next cycle; a new item may start every cycle.
// Dequeue with data on the outbound stack: one RAM read, then the result beat from S_POP.
// Dequeue on an empty outbound stack: the inbound entries move over first, the move
// running one entry per cycle through the single read port of the inbound RAM.
// Async reset empties both stacks, limit back to 16, RAMs kept; results never stall.
module two_stack_queue #(
    parameter int STACK_DEPTH = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // item channel
    input  logic                              start,
    output logic                              busy,
    input  tsq_pkg::item_t                    item,
    // result channel, one beat per item
    output logic                              done,
    output tsq_pkg::result_t                  result,
    // limit register write
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [tsq_pkg::LIMIT_W-1:0]       cfg_data
);

    import tsq_pkg::*;

    `include "two_stack_queue_defines.svh"

    // address, count and compare widths
    localparam int AW = $clog2(STACK_DEPTH);
    localparam int CW = $clog2(STACK_DEPTH + 1);
    localparam int EW = (CW > LIMIT_W) ? CW : LIMIT_W;

    typedef enum logic [1:0] {
        S_IDLE,
        S_MOVE,   // refill: inbound popped onto outbound, one entry a cycle
        S_POP     // outbound read data back, drive the result beat
    } state_t;

    state_t               state_reg, state_next;
    logic [CW-1:0]        in_cnt_reg, in_cnt_next;
    logic [CW-1:0]        out_cnt_reg, out_cnt_next;
    logic                 pend_reg, pend_next;     // inbound read in flight
    logic [LIMIT_W-1:0]   limit_reg;
    logic                 done_reg, done_next;
    result_t              res_reg, res_next;

    logic [EW-1:0]        limit_eff;
    logic [CW-1:0]        in_dec, out_dec;

    // RAM ports
    logic                 in_we, out_we;
    logic [DATA_W-1:0]    in_rdata, out_rdata;

    // Limit of 0 behaves as 1; anything beyond the depth clips to the depth.
    always_comb
    begin
        if (limit_reg == '0)
        begin
            limit_eff = EW'(1);
        end
        else if (EW'(limit_reg) > EW'(STACK_DEPTH))
        begin
            limit_eff = EW'(STACK_DEPTH);
        end
        else
        begin
            limit_eff = EW'(limit_reg);
        end
    end

    assign in_dec  = in_cnt_reg - 1'b1;
    assign out_dec = out_cnt_reg - 1'b1;

    // sequencer
    always_comb
    begin
        state_next   = state_reg;
        in_cnt_next  = in_cnt_reg;
        out_cnt_next = out_cnt_reg;
        pend_next    = pend_reg;
        done_next    = 1'b0;
        res_next     = res_reg;
        in_we        = 1'b0;
        out_we       = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    if (item.kind == KIND_ENQ)
                    begin
                        done_next = 1'b1;
                        res_next.data_out = '0;
                        if (EW'(in_cnt_reg) >= limit_eff)
                        begin
                            res_next.status = ST_OVERFLOW;
                        end
                        else
                        begin
                            in_we = 1'b1;
                            in_cnt_next = in_cnt_reg + 1'b1;
                            res_next.status = ST_OK;
                        end
                    end
                    else if (out_cnt_reg != '0)
                    begin
                        // read address is out_dec this cycle
                        out_cnt_next = out_dec;
                        state_next = S_POP;
                    end
                    else if (in_cnt_reg == '0)
                    begin
                        done_next = 1'b1;
                        res_next.data_out = UNDERFLOW_DATA;
                        res_next.status = ST_UNDERFLOW;
                    end
                    else
                    begin
                        pend_next = 1'b0;
                        state_next = S_MOVE;
                    end
                end
            end

            S_MOVE:
            begin
                // land last cycle's read; entries beyond the limit are lost
                if (pend_reg && (EW'(out_cnt_reg) < limit_eff))
                begin
                    out_we = 1'b1;
                    out_cnt_next = out_cnt_reg + 1'b1;
                end
                if (in_cnt_reg != '0)
                begin
                    in_cnt_next = in_dec;
                    pend_next = 1'b1;
                end
                else
                begin
                    pend_next = 1'b0;
                    if (!pend_reg)
                    begin
                        // move finished, outbound holds at least one entry
                        out_cnt_next = out_dec;
                        state_next = S_POP;
                    end
                end
            end

            S_POP:
            begin
                done_next = 1'b1;
                res_next.data_out = out_rdata;
                res_next.status = ST_OK;
                state_next = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            in_cnt_reg  <= '0;
            out_cnt_reg <= '0;
            pend_reg    <= 1'b0;
            done_reg    <= 1'b0;
            limit_reg   <= LIMIT_RESET;
        end
        else
        begin
            state_reg   <= state_next;
            in_cnt_reg  <= in_cnt_next;
            out_cnt_reg <= out_cnt_next;
            pend_reg    <= pend_next;
            done_reg    <= done_next;
            if (cfg_valid && cfg_ready)
            begin
                limit_reg <= cfg_data;
            end
        end
    end

    // result payload needs no reset
    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

    // Inbound stack: pushed from the item, read at top-of-stack for the move.
    tsq_ram #(
        .WIDTH (DATA_W),
        .DEPTH (STACK_DEPTH)
    ) u_in_ram (
        .clk   (clk),
        .we    (in_we),
        .waddr (in_cnt_reg[AW-1:0]),
        .wdata (item.data_in),
        .raddr (in_dec[AW-1:0]),
        .rdata (in_rdata)
    );

    // Outbound stack: filled by the move, read at top-of-stack on a pop.
    tsq_ram #(
        .WIDTH (DATA_W),
        .DEPTH (STACK_DEPTH)
    ) u_out_ram (
        .clk   (clk),
        .we    (out_we),
        .waddr (out_cnt_reg[AW-1:0]),
        .wdata (in_rdata),
        .raddr (out_dec[AW-1:0]),
        .rdata (out_rdata)
    );

    assign busy      = (state_reg != S_IDLE);
    assign cfg_ready = (state_reg == S_IDLE);
    assign done      = done_reg;
    assign result    = res_reg;

    `TSQ_ASSERT_IMP(a_in_cnt_bound, 1'b1, in_cnt_reg <= CW'(STACK_DEPTH), "inbound count beyond depth")
    `TSQ_ASSERT_IMP(a_out_cnt_bound, 1'b1, out_cnt_reg <= CW'(STACK_DEPTH), "outbound count beyond depth")
    `TSQ_ASSERT_NXT(a_enq_beat, start && !busy && item.kind == KIND_ENQ, done, "enqueue gave no beat")
    `TSQ_ASSERT_IMP(a_beat_idle, done, !busy, "result beat while busy")
    `TSQ_ASSERT_IMP(a_underflow_empty, done && result.status == ST_UNDERFLOW, in_cnt_reg == '0 && out_cnt_reg == '0, "underflow with data held")

endmodule

// ===== rtl/tsq_ram.sv =====
// Generic simple dual-port RAM, one write and one registered read port.
module tsq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
